// ===== rtl/core/dtq_pkg.sv =====
package dtq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ACT_SCHEDULE = 2'd0;
  localparam logic [1:0] ACT_CANCEL   = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;

  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NO_EXPIRY = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now;
    logic [31:0] deadline;
    logic [31:0] cancel_id;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] event_id;
    logic        armed;
    logic [31:0] next_delay;
    logic        last;
  } rsp_item_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_NEXT_ID,
    RS_CANCEL_ID,
    RS_ENTRY
  } res_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT_SCAN,
    S_CANCEL_SCAN,
    S_TICK,
    S_PUT
  } dtq_state_t;

  typedef struct packed {
    logic       latch;
    logic       idx_inc;
    logic       insert;
    logic       remove;
    logic       res_load;
    logic [2:0] res_code;
    res_sel_t   res_sel;
    logic       put;
  } dtq_cmd_t;

  typedef struct packed {
    logic full;
    logic at_end;
    logic ins_here;
    logic id_match;
    logic more;
    logic out_free;
    logic last;
  } dtq_sts_t;

endpackage

// ===== rtl/core/dtq_datapath.sv =====
module dtq_datapath import dtq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dtq_cmd_t  cmd,
  output dtq_sts_t  sts,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  req_item_t        req_q;
  logic [31:0]      dl_mem [DEPTH];
  logic [31:0]      id_mem [DEPTH];
  logic [CNT_W-1:0] count;
  logic [31:0]      next_id;
  logic [CNT_W-1:0] idx;
  logic [NUM_W-1:0] n_done;
  logic [2:0]       res_status;
  logic [31:0]      res_id;
  logic [31:0]      dl_at;
  logic [31:0]      id_at;
  logic             head_late;

  assign dl_at = dl_mem[idx[IDX_W-1:0]];
  assign id_at = id_mem[idx[IDX_W-1:0]];
  assign head_late = (count != '0) && (dl_mem[0] > req_q.now);

  always_comb begin
    sts.full     = (count == CNT_W'(DEPTH));
    sts.at_end   = (idx >= count);
    sts.ins_here = (idx >= count) || (dl_at >= req_q.deadline);
    sts.id_match = (id_at == req_q.cancel_id);
    sts.more     = (n_done < NUM_W'(MAX_RESULTS)) && (count != '0) &&
                   (dl_mem[0] <= req_q.now);
    sts.out_free = !rsp_valid || rsp_ready;
    sts.last     = !((req_q.action == ACT_TICK) && sts.more);
  end

  // sorted entry array, shifted up on insert and down on remove
  for (genvar j = 0; j < DEPTH; j++) begin : g_entry
    logic [31:0] dl_prev, id_prev, dl_nxt, id_nxt;
    if (j == 0) begin : g_first
      assign dl_prev = req_q.deadline;
      assign id_prev = next_id;
    end else begin : g_mid
      assign dl_prev = dl_mem[j-1];
      assign id_prev = id_mem[j-1];
    end
    if (j == DEPTH - 1) begin : g_top
      assign dl_nxt = dl_mem[j];
      assign id_nxt = id_mem[j];
    end else begin : g_below
      assign dl_nxt = dl_mem[j+1];
      assign id_nxt = id_mem[j+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (CNT_W'(j) == idx) begin
          dl_mem[j] <= req_q.deadline;
          id_mem[j] <= next_id;
        end else if (CNT_W'(j) > idx) begin
          dl_mem[j] <= dl_prev;
          id_mem[j] <= id_prev;
        end
      end else if (cmd.remove && (CNT_W'(j) >= idx)) begin
        dl_mem[j] <= dl_nxt;
        id_mem[j] <= id_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      unique case (cmd.res_sel)
        RS_ZERO:      res_id <= '0;
        RS_NEXT_ID:   res_id <= next_id;
        RS_CANCEL_ID: res_id <= req_q.cancel_id;
        RS_ENTRY:     res_id <= id_at;
      endcase
    end
    if (cmd.put) begin
      rsp.status     <= res_status;
      rsp.event_id   <= res_id;
      rsp.armed      <= (count != '0);
      rsp.next_delay <= head_late ? (dl_mem[0] - req_q.now) : '0;
      rsp.last       <= sts.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      next_id   <= 32'd1;
      idx       <= '0;
      n_done    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        idx    <= '0;
        n_done <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.insert) begin
        count   <= count + 1'b1;
        next_id <= next_id + 32'd1;
      end else if (cmd.remove) begin
        count  <= count - 1'b1;
        n_done <= n_done + 1'b1;
      end
      if (cmd.put) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/dtq_ctrl.sv =====
module dtq_ctrl import dtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_action,
  output logic       req_ready,
  input  dtq_sts_t   sts,
  output dtq_cmd_t   cmd
);

  dtq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_action)
            ACT_SCHEDULE: state_next = S_INSERT_SCAN;
            ACT_CANCEL:   state_next = S_CANCEL_SCAN;
            ACT_TICK:     state_next = S_TICK;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_INSERT_SCAN: begin
        if (sts.full || sts.ins_here) begin
          state_next = S_PUT;
        end
      end
      S_CANCEL_SCAN: begin
        if (sts.at_end || sts.id_match) begin
          state_next = S_PUT;
        end
      end
      S_TICK: state_next = S_PUT;
      S_PUT: begin
        if (sts.out_free) begin
          state_next = sts.last ? S_IDLE : S_TICK;
        end
      end
    endcase
  end

  always_comb begin
    req_ready    = (state == S_IDLE);
    cmd          = '0;
    cmd.res_sel  = RS_ZERO;
    cmd.latch    = (state == S_IDLE) && req_valid;
    unique case (state)
      S_IDLE: ;
      S_INSERT_SCAN: begin
        if (sts.full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_FULL;
        end else if (sts.ins_here) begin
          cmd.insert   = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_SCHEDULED;
          cmd.res_sel  = RS_NEXT_ID;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CANCEL_SCAN: begin
        if (sts.at_end) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end else if (sts.id_match) begin
          cmd.remove   = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_CANCELLED;
          cmd.res_sel  = RS_CANCEL_ID;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TICK: begin
        cmd.res_load = 1'b1;
        if (sts.more) begin
          cmd.remove   = 1'b1;
          cmd.res_code = ST_EXPIRED;
          cmd.res_sel  = RS_ENTRY;
        end else begin
          cmd.res_code = ST_NO_EXPIRY;
        end
      end
      S_PUT: cmd.put = sts.out_free;
    endcase
  end

endmodule

// ===== rtl/core/deadline_timer_queue_core.sv =====
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req_item_t: action, now, deadline, cancel_id
// rsp      out        rsp_valid / rsp_ready  rsp_item_t: status, event_id, armed, next_delay, last
//
// one request at a time; req_ready is high only while the controller is idle
// schedule and cancel walk the sorted queue one entry per cycle
// tick passes through its tick and put states once per result, up to MAX_RESULTS results
// the response register lets the next request in while the last result is still held
// a stalled rsp holds the controller in its put state; reset empties the queue, next id 1
module deadline_timer_queue_core import dtq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  dtq_cmd_t cmd;
  dtq_sts_t sts;

  dtq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_ready  (req_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dtq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.full)
    else $error("insert into full queue");

  a_put_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> sts.out_free)
    else $error("result overwritten");

  a_remove_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> !sts.at_end)
    else $error("remove past queue end");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.insert, cmd.remove, cmd.idx_inc}))
    else $error("conflicting queue operations");

endmodule

// ===== bench/tb_deadline_timer_queue_core.sv =====
`timescale 1ns / 100ps

module tb_deadline_timer_queue_core;
  import dtq_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int RANDOM_REQS  = 250;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AFTER   = 40;

  typedef struct {
    req_item_t item;
    bit        typed;
    rsp_item_t outcome;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;

  logic [31:0] slot_deadline [DEPTH];
  logic [31:0] slot_id [DEPTH];
  int unsigned slot_count;
  logic [31:0] id_counter;
  rsp_item_t   step_out [MAX_RESULTS];

  rsp_item_t   queued_outcomes [$];
  stim_row_t   directed_rows [$];
  logic [31:0] sim_now;
  int          granted_reqs;
  int          mismatches;
  int          quiet_cycles;
  bit          long_hold_done;

  deadline_timer_queue_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rsp_item_t make_outcome(logic [2:0] status, logic [31:0] event_id,
                                             logic [31:0] now);
    rsp_item_t o;
    o.status     = status;
    o.event_id   = event_id;
    o.armed      = (slot_count != 0);
    o.next_delay = (slot_count != 0 && slot_deadline[0] > now) ? slot_deadline[0] - now : 32'd0;
    o.last       = 1'b0;
    return o;
  endfunction

  function automatic void drop_slot(int unsigned pos);
    for (int unsigned j = pos; j + 1 < slot_count; j++) begin
      slot_deadline[j] = slot_deadline[j + 1];
      slot_id[j]       = slot_id[j + 1];
    end
    slot_count--;
  endfunction

  // fills step_out with the results of one request, returns how many
  function automatic int timer_queue_step(req_item_t r);
    int          n;
    int unsigned pos;
    bit          hit;
    logic [31:0] gone;
    n = 0;
    case (r.action)
      ACT_SCHEDULE: begin
        if (slot_count >= DEPTH) begin
          step_out[0] = make_outcome(ST_FULL, 32'd0, r.now);
        end else begin
          pos = 0;
          while (pos < slot_count && slot_deadline[pos] < r.deadline) pos++;
          for (int unsigned i = slot_count; i > pos; i--) begin
            slot_deadline[i] = slot_deadline[i - 1];
            slot_id[i]       = slot_id[i - 1];
          end
          slot_deadline[pos] = r.deadline;
          slot_id[pos]       = id_counter;
          slot_count++;
          step_out[0] = make_outcome(ST_SCHEDULED, id_counter, r.now);
          id_counter++;
        end
        n = 1;
      end
      ACT_CANCEL: begin
        hit = 1'b0;
        pos = 0;
        while (!hit && pos < slot_count) begin
          if (slot_id[pos] == r.cancel_id) hit = 1'b1;
          else pos++;
        end
        if (hit) begin
          drop_slot(pos);
          step_out[0] = make_outcome(ST_CANCELLED, r.cancel_id, r.now);
        end else begin
          step_out[0] = make_outcome(ST_NOT_FOUND, 32'd0, r.now);
        end
        n = 1;
      end
      ACT_TICK: begin
        while (n < MAX_RESULTS && slot_count > 0 && slot_deadline[0] <= r.now) begin
          gone = slot_id[0];
          drop_slot(0);
          step_out[n] = make_outcome(ST_EXPIRED, gone, r.now);
          n++;
        end
        if (n == 0) begin
          step_out[0] = make_outcome(ST_NO_EXPIRY, 32'd0, r.now);
          n = 1;
        end
      end
      default: n = 0;
    endcase
    if (n > 0) step_out[n - 1].last = 1'b1;
    return n;
  endfunction

  function automatic void add_row(logic [1:0] action, logic [31:0] now, logic [31:0] deadline,
                                  logic [31:0] cancel_id);
    stim_row_t row;
    row.item.action    = action;
    row.item.now       = now;
    row.item.deadline  = deadline;
    row.item.cancel_id = cancel_id;
    row.typed          = 1'b0;
    row.outcome        = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(logic [1:0] action, logic [31:0] now,
                                          logic [31:0] deadline, logic [31:0] cancel_id,
                                          logic [2:0] status, logic [31:0] event_id,
                                          logic armed, logic [31:0] next_delay);
    stim_row_t row;
    row.item.action        = action;
    row.item.now           = now;
    row.item.deadline      = deadline;
    row.item.cancel_id     = cancel_id;
    row.typed              = 1'b1;
    row.outcome.status     = status;
    row.outcome.event_id   = event_id;
    row.outcome.armed      = armed;
    row.outcome.next_delay = next_delay;
    row.outcome.last       = 1'b1;
    directed_rows.push_back(row);
  endfunction

  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_item_t random_request(bit fill_phase);
    req_item_t   r;
    int unsigned pick;
    r.action    = ACT_TICK;
    r.now       = sim_now;
    r.deadline  = $urandom;
    r.cancel_id = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.action = ACT_UNKNOWN;
      r.now    = $urandom;
    end else if (pick < (fill_phase ? 60 : 25)) begin
      r.action = ACT_SCHEDULE;
      case ($urandom_range(0, 9))
        0: r.deadline = $urandom;
        1: if (slot_count != 0) r.deadline = slot_deadline[$urandom_range(0, slot_count - 1)];
        default: r.deadline = sim_now + $urandom_range(0, 400);
      endcase
      if ($urandom_range(0, 9) == 0) r.now = $urandom;
    end else if (pick < (fill_phase ? 80 : 60)) begin
      r.action = ACT_CANCEL;
      if (slot_count != 0 && $urandom_range(0, 3) != 0)
        r.cancel_id = slot_id[$urandom_range(0, slot_count - 1)];
      else if ($urandom_range(0, 1) == 0)
        r.cancel_id = id_counter - $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) r.now = $urandom;
    end else begin
      if ($urandom_range(0, 19) == 0) sim_now = $urandom;
      else sim_now = sim_now + $urandom_range(0, 150);
      r.now = sim_now;
    end
    return r;
  endfunction

  // returns at the rising edge where the request is taken
  task automatic offer_request(input req_item_t item);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic run_request(input req_item_t item, input bit typed, input rsp_item_t outcome);
    int n;
    offer_request(item);
    n = timer_queue_step(item);
    if (typed) begin
      queued_outcomes.push_back(outcome);
    end else begin
      for (int j = 0; j < n; j++) queued_outcomes.push_back(step_out[j]);
    end
    granted_reqs++;
  endtask

  initial begin
    req_item_t item;
    int        useful;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    slot_count     = 0;
    id_counter     = 32'd1;
    sim_now        = 32'd0;
    granted_reqs   = 0;
    mismatches     = 0;
    long_hold_done = 1'b0;

    add_checked_row(ACT_TICK, 32'd0, 32'd0, 32'd0, ST_NO_EXPIRY, 32'd0, 1'b0, 32'd0);
    add_checked_row(ACT_CANCEL, 32'd0, 32'd0, 32'd0, ST_NOT_FOUND, 32'd0, 1'b0, 32'd0);
    add_row(ACT_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_checked_row(ACT_SCHEDULE, 32'd0, 32'hFFFF_FFFF, 32'd0,
                    ST_SCHEDULED, 32'd1, 1'b1, 32'hFFFF_FFFF);
    add_checked_row(ACT_SCHEDULE, 32'hFFFF_FFFF, 32'd0, 32'd0,
                    ST_SCHEDULED, 32'd2, 1'b1, 32'd0);
    // equal deadline goes ahead of the older entry
    add_row(ACT_SCHEDULE, 32'd0, 32'd0, 32'd0);
    add_row(ACT_CANCEL, 32'd0, 32'd0, 32'd2);
    add_row(ACT_TICK, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < DEPTH - 1; i++)
      add_row(ACT_SCHEDULE, 32'd4000, 32'd5000 - 32'd300 * (i % 5), 32'd0);
    add_checked_row(ACT_SCHEDULE, 32'd4000, 32'd1234, 32'd0, ST_FULL, 32'd0, 1'b1, 32'd0);
    add_row(ACT_TICK, 32'hFFFF_FFFF, 32'd0, 32'd0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      run_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].outcome);

    useful = 0;
    while (useful < RANDOM_REQS) begin
      item = random_request(((useful / 35) % 2) == 0);
      run_request(item, 1'b0, '0);
      if (item.action != ACT_UNKNOWN) useful++;
    end

    @(negedge clk);
    req_valid <= 1'b0;
    while (queued_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // result side, with one long hold-off so the block backs up onto the request side
  initial begin
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && granted_reqs >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_ready <= 1'b0;
        repeat (idle_gap() + 1) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (queued_outcomes.size() == 0) begin
        $error("unexpected result: status %0d event_id %0h", rsp.status, rsp.event_id);
        mismatches++;
      end else begin
        want = queued_outcomes.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.event_id !== want.event_id) begin
          $error("event_id: expected %0h, got %0h", want.event_id, rsp.event_id);
          mismatches++;
        end
        if (rsp.armed !== want.armed) begin
          $error("armed: expected %0b, got %0b", want.armed, rsp.armed);
          mismatches++;
        end
        if (rsp.next_delay !== want.next_delay) begin
          $error("next_delay: expected %0h, got %0h", want.next_delay, rsp.next_delay);
          mismatches++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
